// ===== src/swux_pkg.sv =====
`default_nettype none

package swux_pkg;

  localparam int TickCounterBits = 16;
  localparam int CfgBits = 16;
  localparam logic [31:0] TickCap = 32'((64'd1 << TickCounterBits) - 64'd1);
  localparam logic [31:0] MinBitTicks = 32'd2;

  typedef logic [TickCounterBits-1:0] tick_t;

  typedef struct packed {
    logic       send_request;
    logic [7:0] send_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       reply_valid;
    logic [7:0] reply_byte;
  } res_t;

  // clamp the configured bit time into the tick counter range
  function automatic tick_t bit_time(logic [CfgBits-1:0] ticks);
    logic [31:0] d;
    d = {{(32 - CfgBits){1'b0}}, ticks};
    if (d < MinBitTicks) d = MinBitTicks;
    if (d > TickCap) d = TickCap;
    return d[TickCounterBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/single_wire_uart_exchange.sv =====
// channel   signals                                   direction
// in        in_valid in_ready send_request send_byte  into block
//           line_level
// out       out_valid out_ready drive_low busy_res    out of block
//           reply_valid reply_byte
// cfg       cfg_valid cfg_ready bit_ticks             into block
//
// one transaction in gives one transaction out, through the input and result registers
// a new input transaction is taken every cycle while out_ready is high
// the engine state advances once per tick, between the input and result registers
// rst is synchronous: idle phase, bit_ticks 240, both pipeline registers empty
// a stalled output holds its result and the input register fills, then in_ready drops
`default_nettype none

module single_wire_uart_exchange (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        send_request,
  input  wire logic [7:0]  send_byte,
  input  wire logic        line_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             drive_low,
  output logic             busy_res,
  output logic             reply_valid,
  output logic [7:0]       reply_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] bit_ticks
);

  swux_pkg::item_t in_item;
  swux_pkg::item_t item;
  swux_pkg::res_t  res;
  swux_pkg::res_t  res_q;
  logic            item_valid;
  logic            advance;

  assign in_item.send_request = send_request;
  assign in_item.send_byte    = send_byte;
  assign in_item.line_level   = line_level;

  assign cfg_ready = 1'b1;

  swux_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  swux_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (bit_ticks),
    .advance   (advance),
    .item      (item),
    .res       (res)
  );

  swux_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res_in     (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_out    (res_q)
  );

  assign drive_low   = res_q.drive_low;
  assign busy_res    = res_q.busy_res;
  assign reply_valid = res_q.reply_valid;
  assign reply_byte  = res_q.reply_byte;

endmodule

`default_nettype wire

// ===== src/swux_in_stage.sv =====
`default_nettype none

module swux_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire swux_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output swux_pkg::item_t      item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/swux_engine.sv =====
`default_nettype none

module swux_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [swux_pkg::CfgBits-1:0]      cfg_data,
  input  wire logic                              advance,
  input  wire swux_pkg::item_t                   item,
  output swux_pkg::res_t                         res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_PRE    = 4'd1,
    PH_START  = 4'd2,
    PH_DATA   = 4'd3,
    PH_STOP   = 4'd4,
    PH_ARM    = 4'd5,
    PH_HALF   = 4'd6,
    PH_RXBIT  = 4'd7,
    PH_RXSTOP = 4'd8
  } phase_t;

  logic [swux_pkg::CfgBits-1:0] bit_ticks;
  phase_t                       phase, phase_next;
  swux_pkg::tick_t              tick_count, tick_count_next;
  logic [2:0]                   bit_index, bit_index_next;
  logic [7:0]                   tx_shift, tx_shift_next;
  logic [7:0]                   rx_shift, rx_shift_next;
  logic                         last_level;

  swux_pkg::tick_t dur;
  swux_pkg::tick_t tick_inc;
  swux_pkg::tick_t limit;
  logic            done;
  logic            valid;

  assign dur      = swux_pkg::bit_time(bit_ticks);
  assign tick_inc = tick_count + swux_pkg::tick_t'(1);
  assign limit    = (phase == PH_HALF) ? (dur >> 1) : dur;
  assign done     = tick_inc >= limit;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    valid           = 1'b0;
    unique case (phase)
      PH_PRE, PH_START, PH_DATA, PH_STOP, PH_HALF, PH_RXBIT, PH_RXSTOP: begin
        tick_count_next = done ? '0 : tick_inc;
        if (done) begin
          case (phase)
            PH_PRE: phase_next = PH_START;
            PH_START: begin
              phase_next     = PH_DATA;
              bit_index_next = 3'd0;
            end
            PH_DATA: begin
              if (bit_index == 3'd7) begin
                phase_next     = PH_STOP;
                bit_index_next = 3'd0;
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end
            PH_STOP: phase_next = PH_ARM;
            PH_HALF: begin
              phase_next     = PH_RXBIT;
              bit_index_next = 3'd0;
            end
            PH_RXBIT: begin
              rx_shift_next = {rx_shift[6:0], item.line_level};
              if (bit_index == 3'd7) begin
                phase_next     = PH_RXSTOP;
                bit_index_next = 3'd0;
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end
            default: begin
              valid      = 1'b1;
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
      PH_ARM: begin
        if (last_level && !item.line_level) begin
          phase_next      = PH_HALF;
          tick_count_next = '0;
          rx_shift_next   = 8'd0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.send_request) begin
          tx_shift_next   = item.send_byte;
          tick_count_next = '0;
          bit_index_next  = 3'd0;
          phase_next      = PH_PRE;
        end
      end
    endcase
  end

  always_comb begin
    res.drive_low = 1'b0;
    if (phase_next == PH_START) begin
      res.drive_low = 1'b1;
    end else if (phase_next == PH_DATA) begin
      res.drive_low = !tx_shift_next[3'd7 - bit_index_next];
    end
    res.busy_res    = phase_next != PH_IDLE;
    res.reply_valid = valid;
    res.reply_byte  = valid ? rx_shift : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks  <= swux_pkg::CfgBits'(240);
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= 3'd0;
      tx_shift   <= 8'd0;
      rx_shift   <= 8'd0;
      last_level <= 1'b1;
    end else begin
      if (cfg_write) begin
        bit_ticks <= cfg_data;
      end
      if (advance) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        bit_index  <= bit_index_next;
        tx_shift   <= tx_shift_next;
        rx_shift   <= rx_shift_next;
        last_level <= item.line_level;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_reply_ends_busy: assert property (@(posedge clk) disable iff (rst)
    res.reply_valid |-> !res.busy_res)
    else $error("reply reported while still busy");

  a_drive_only_busy: assert property (@(posedge clk) disable iff (rst)
    res.drive_low |-> res.busy_res)
    else $error("line driven outside an exchange");

  a_reply_zero: assert property (@(posedge clk) disable iff (rst)
    !res.reply_valid |-> res.reply_byte == 8'd0)
    else $error("reply byte nonzero without reply");

  a_index_idle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_DATA && phase != PH_RXBIT) |-> bit_index == 3'd0)
    else $error("bit index left over outside a bit phase");

  a_arm_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ARM || phase == PH_IDLE) |-> tick_count == '0)
    else $error("tick counter running while waiting");
`endif

endmodule

`default_nettype wire

// ===== src/swux_out_stage.sv =====
`default_nettype none

module swux_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire swux_pkg::res_t res_in,
  output logic                advance,
  output logic                out_valid,
  input  wire logic           out_ready,
  output swux_pkg::res_t      res_out
);

  assign advance = item_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== tb/single_wire_uart_exchange_tb.sv =====
`default_nettype none

module single_wire_uart_exchange_tb;

  typedef enum logic [3:0] {
    X_IDLE   = 4'd0,
    X_PRE    = 4'd1,
    X_START  = 4'd2,
    X_DATA   = 4'd3,
    X_STOP   = 4'd4,
    X_ARM    = 4'd5,
    X_HALF   = 4'd6,
    X_RXBIT  = 4'd7,
    X_RXSTOP = 4'd8
  } xchg_phase_t;

  typedef enum int {
    XK_CLEAN,
    XK_NOISY,
    XK_LONG_WAIT,
    XK_RANDOM_RX
  } xchg_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        send_request = 1'b0;
  logic [7:0]  send_byte = 8'h00;
  logic        line_level = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        drive_low;
  logic        busy_res;
  logic        reply_valid;
  logic [7:0]  reply_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_bit_ticks = 16'd240;

  single_wire_uart_exchange uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .send_request (send_request),
    .send_byte    (send_byte),
    .line_level   (line_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_low    (drive_low),
    .busy_res     (busy_res),
    .reply_valid  (reply_valid),
    .reply_byte   (reply_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .bit_ticks    (cfg_bit_ticks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the exchange engine
  logic [15:0] live_bit_ticks = 16'd240;
  xchg_phase_t xphase = X_IDLE;
  logic [15:0] tick_cnt = 16'd0;
  logic [2:0]  bit_idx = 3'd0;
  logic [7:0]  tx_sh = 8'h00;
  logic [7:0]  rx_sh = 8'h00;
  logic        prev_level = 1'b1;

  swux_pkg::item_t tick_queue[$];
  swux_pkg::res_t  predicted_outputs[$];

  int errors = 0;
  int accepted_ticks = 0;
  int outputs_seen = 0;
  int replies_seen = 0;
  int exchanges_queued = 0;
  int settings_used = 0;

  function automatic logic [15:0] clamped_bit_time(input logic [15:0] v);
    return (v < 16'd2) ? 16'd2 : v;
  endfunction

  function automatic bit count_tick(input logic [15:0] dur);
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= dur) begin
      tick_cnt = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_exchange(input swux_pkg::item_t it, output swux_pkg::res_t r);
    logic [15:0] dur;
    dur = clamped_bit_time(live_bit_ticks);
    r = '0;
    case (xphase)
      X_PRE: begin
        if (count_tick(dur)) xphase = X_START;
      end
      X_START: begin
        if (count_tick(dur)) begin
          xphase = X_DATA;
          bit_idx = 3'd0;
        end
      end
      X_DATA: begin
        if (count_tick(dur)) begin
          if (bit_idx == 3'd7) begin
            xphase = X_STOP;
            bit_idx = 3'd0;
          end else begin
            bit_idx = bit_idx + 3'd1;
          end
        end
      end
      X_STOP: begin
        if (count_tick(dur)) xphase = X_ARM;
      end
      X_ARM: begin
        if (prev_level && !it.line_level) begin
          xphase = X_HALF;
          tick_cnt = 16'd0;
          rx_sh = 8'h00;
        end
      end
      X_HALF: begin
        if (count_tick(dur >> 1)) begin
          xphase = X_RXBIT;
          bit_idx = 3'd0;
        end
      end
      X_RXBIT: begin
        if (count_tick(dur)) begin
          rx_sh = {rx_sh[6:0], it.line_level};
          if (bit_idx == 3'd7) begin
            xphase = X_RXSTOP;
            bit_idx = 3'd0;
          end else begin
            bit_idx = bit_idx + 3'd1;
          end
        end
      end
      X_RXSTOP: begin
        if (count_tick(dur)) begin
          r.reply_valid = 1'b1;
          r.reply_byte = rx_sh;
          xphase = X_IDLE;
        end
      end
      default: begin
        xphase = X_IDLE;
        if (it.send_request) begin
          tx_sh = it.send_byte;
          tick_cnt = 16'd0;
          bit_idx = 3'd0;
          xphase = X_PRE;
        end
      end
    endcase
    prev_level = it.line_level;
    r.drive_low = (xphase == X_START) || (xphase == X_DATA && !tx_sh[3'd7 - bit_idx]);
    r.busy_res = (xphase != X_IDLE);
  endtask

  // sender: bursts and gaps, plus occasional hold until all outputs are back
  swux_pkg::item_t cur_tick;
  swux_pkg::res_t  nxt_out;
  int              burst_left = 0;
  int              gap_left = 0;
  bit              drain_hold = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_exchange(cur_tick, nxt_out);
        predicted_outputs.push_back(nxt_out);
        accepted_ticks++;
        if (accepted_ticks % 337 == 0) drain_hold = 1'b1;
      end
      if (!in_valid || in_ready) begin
        if (drain_hold && predicted_outputs.size() == 0) drain_hold = 1'b0;
        if (!drain_hold && gap_left == 0 && tick_queue.size() != 0) begin
          cur_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          send_request <= cur_tick.send_request;
          send_byte <= cur_tick.send_byte;
          line_level <= cur_tick.line_level;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: rotates among four stall modes: always ready, mostly ready, a fixed pattern and random
  logic [15:0]    stall_pat = 16'b1011_0011_1110_0101;
  int             stall_cyc = 0;
  swux_pkg::res_t want;

  task automatic note_mismatch(input string field, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        outputs_seen++;
        if (reply_valid) replies_seen++;
        if (predicted_outputs.size() == 0) begin
          note_mismatch("unpredicted transaction reply_byte", 8'h00, reply_byte);
        end else begin
          want = predicted_outputs.pop_front();
          if (drive_low !== want.drive_low)
            note_mismatch("drive_low", 8'(want.drive_low), 8'(drive_low));
          if (busy_res !== want.busy_res)
            note_mismatch("busy_res", 8'(want.busy_res), 8'(busy_res));
          if (reply_valid !== want.reply_valid)
            note_mismatch("reply_valid", 8'(want.reply_valid), 8'(reply_valid));
          if (reply_byte !== want.reply_byte)
            note_mismatch("reply_byte", want.reply_byte, reply_byte);
        end
      end
      stall_cyc++;
      case ((stall_cyc >> 7) & 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= stall_pat[stall_cyc[3:0]];
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void push_tick(input logic req, input logic [7:0] b, input logic lv);
    swux_pkg::item_t it;
    it.send_request = req;
    it.send_byte = b;
    it.line_level = lv;
    tick_queue.push_back(it);
  endfunction

  // one request, transmit, armed wait, falling edge, eight received bits, stop
  task automatic gen_exchange(input int d, input logic [7:0] tx, input logic [7:0] rx,
                              input xchg_kind_t kind);
    int   waits;
    logic lv;
    exchanges_queued++;
    push_tick(1'b1, tx, 1'b1);
    for (int k = 1; k <= 11 * d; k++) begin
      lv = (kind == XK_NOISY && k != 11 * d) ? rand_bit() : 1'b1;
      push_tick(rand_bit(), 8'($urandom), lv);
    end
    waits = (kind == XK_LONG_WAIT) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    repeat (waits) push_tick(rand_bit(), 8'($urandom), 1'b1);
    push_tick(rand_bit(), 8'($urandom), 1'b0);
    repeat (d / 2) push_tick(rand_bit(), 8'($urandom), (kind == XK_NOISY) ? rand_bit() : 1'b0);
    for (int b = 7; b >= 0; b--) begin
      for (int k = 1; k <= d; k++) begin
        if (kind == XK_RANDOM_RX) lv = rand_bit();
        else if (k == d || kind == XK_CLEAN) lv = rx[3'(b)];
        else lv = rand_bit();
        push_tick(rand_bit(), 8'($urandom), lv);
      end
    end
    repeat (d) push_tick(rand_bit(), 8'($urandom), 1'b1);
    repeat ($urandom_range(0, 3)) push_tick(1'b0, 8'($urandom), rand_bit());
  endtask

  // brings the engine back to idle from any phase, no requests
  task automatic gen_recover(input int d);
    repeat (11 * d + 2) push_tick(1'b0, 8'($urandom), 1'b1);
    push_tick(1'b0, 8'($urandom), 1'b0);
    repeat (10 * d + 2) push_tick(1'b0, 8'($urandom), 1'b1);
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_valid) @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bit_ticks(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_bit_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_bit_ticks = v;
    settings_used++;
  endtask

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          counted;
    int          mark;
    int          d;
    int          roll;
    logic [15:0] v;
    counted = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset bit time, request then requests while busy
    push_tick(1'b0, 8'hFF, 1'b0);
    push_tick(1'b0, 8'h00, 1'b1);
    push_tick(1'b0, 8'hFF, 1'b0);
    push_tick(1'b1, 8'hA5, 1'b1);
    push_tick(1'b1, 8'h5A, 1'b0);
    push_tick(1'b1, 8'hC3, 1'b1);
    push_tick(1'b1, 8'h00, 1'b0);
    drain();

    // largest bit time, then smallest via zero
    write_bit_ticks(16'hFFFF);
    repeat (4) push_tick(rand_bit(), 8'($urandom), rand_bit());
    drain();
    write_bit_ticks(16'd0);
    gen_recover(2);
    gen_exchange(2, 8'hFF, 8'h00, XK_CLEAN);
    gen_exchange(2, 8'h00, 8'hFF, XK_CLEAN);
    drain();
    write_bit_ticks(16'd1);
    gen_exchange(2, 8'h81, 8'h7E, XK_LONG_WAIT);
    drain();

    while (counted < 750) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) v = 16'($urandom_range(0, 1));
      else if (roll == 1) v = 16'($urandom_range(9, 24));
      else v = 16'($urandom_range(2, 6));
      write_bit_ticks(v);
      d = int'(clamped_bit_time(v));
      mark = tick_queue.size();
      while (tick_queue.size() - mark < 150) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          repeat ($urandom_range(1, 6)) push_tick(1'b0, 8'($urandom), rand_bit());
          mark = mark + 0;
        end else if (roll == 1) begin
          gen_exchange(d, 8'($urandom), 8'($urandom), XK_NOISY);
        end else if (roll == 2) begin
          gen_exchange(d, 8'($urandom), 8'($urandom), XK_LONG_WAIT);
        end else if (roll == 3) begin
          gen_exchange(d, 8'($urandom), 8'($urandom), XK_RANDOM_RX);
        end else begin
          gen_exchange(d, 8'($urandom), 8'($urandom), XK_CLEAN);
        end
      end
      counted += tick_queue.size() - mark;
      drain();
    end

    write_bit_ticks(16'd10);
    gen_exchange(10, 8'($urandom), 8'($urandom), XK_CLEAN);
    drain();
    repeat (10) @(posedge clk);

    $display("run: %0d ticks in, %0d outputs checked, %0d replies", accepted_ticks,
             outputs_seen, replies_seen);
    $display("run: %0d exchanges over %0d bit time writes, %0d mismatches",
             exchanges_queued, settings_used, errors);
    if (errors == 0 && predicted_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/swux_pkg.sv
src/swux_in_stage.sv
src/swux_engine.sv
src/swux_out_stage.sv
src/single_wire_uart_exchange.sv
tb/single_wire_uart_exchange_tb.sv
